/* rtl/tcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, types and the output rounding for the truncated causal
// convolution unit.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int MAX_LEN = 64;
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ACC_W   = PROD_W + $clog2(MAX_LEN);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LEN);

    typedef struct packed {
        logic wr;
        logic adv;
        logic clr;
    } tcc_ctrl_t;

    // round half up to q0.16 and saturate
    function automatic logic [DATA_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0]          sum;
        logic [ACC_W-DATA_W:0]   r;
        sum = {1'b0, acc} + (ACC_W + 1)'(1 << (DATA_W - 1));
        r   = sum[ACC_W:DATA_W];
        if (r[ACC_W-DATA_W:DATA_W] != '0) begin
            round_sat = '1;
        end else begin
            round_sat = r[DATA_W-1:0];
        end
    endfunction

endpackage

/* rtl/tcc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_cell
// One tap of the transposed convolution chain: holds a[k] and b[k], shifts b
// toward the head and adds its product into the partial sum from its neighbor.
// ----------------------------------------------------------------------------
module tcc_cell
    import tcc_pkg::*;
(
    input  logic              aclk,
    input  tcc_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] a_in,
    input  logic [DATA_W-1:0] b_in,
    input  logic [DATA_W-1:0] x_in,
    input  logic [DATA_W-1:0] b_nbr,
    input  logic [ACC_W-1:0]  s_nbr,
    output logic [DATA_W-1:0] b_out,
    output logic [ACC_W-1:0]  s_out
);

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [ACC_W-1:0]  s_reg;
    logic [PROD_W-1:0] prod;

    assign prod = a_reg * x_in;

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            a_reg <= a_in;
            b_reg <= b_in;
        end else if (ctrl.adv) begin
            b_reg <= b_nbr;
        end
        if (ctrl.clr) begin
            s_reg <= '0;
        end else if (ctrl.adv) begin
            s_reg <= s_nbr + ACC_W'(prod);
        end
    end

    assign b_out = b_reg;
    assign s_out = s_reg;

endmodule

/* rtl/tcc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_ctrl
// Load and run sequencer with the output register: counts loaded pairs,
// steps the cell chain once per term and rounds the head sum into the result.
// ----------------------------------------------------------------------------
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_in_last,
    input  logic [ACC_W-1:0]  head_sum,
    output tcc_ctrl_t         ctrl,
    output logic [IDX_W-1:0]  wr_idx,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_conv_value,
    output logic              m_out_last
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] value_reg;
    logic              last_reg;

    logic in_xfer;
    logic not_full;
    logic cap;
    logic adv;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_xfer  = s_valid && s_ready;
    assign not_full = (count_reg < CNT_FULL);
    assign cap      = pend_reg && (!valid_reg || m_ready);
    assign adv      = (state_reg == ST_RUN) && (step_reg != len_reg) && (!pend_reg || cap);

    assign ctrl.wr  = in_xfer && not_full;
    assign ctrl.clr = in_xfer && s_in_last;
    assign ctrl.adv = adv;
    assign wr_idx   = count_reg[IDX_W-1:0];

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        step_next      = step_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        valid_next     = valid_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (s_in_last) begin
                        len_next   = not_full ? count_reg + CNT_W'(1) : CNT_FULL;
                        count_next = '0;
                        step_next  = '0;
                        state_next = ST_RUN;
                    end else if (not_full) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_RUN: begin
                if (cap) begin
                    pend_next = 1'b0;
                    if (pend_last_reg) begin
                        state_next = ST_LOAD;
                    end
                end
                if (adv) begin
                    step_next      = step_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (step_reg + CNT_W'(1) == len_reg);
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        if (cap) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            len_reg       <= '0;
            step_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            step_reg      <= step_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap) begin
            value_reg <= round_sat(head_sum);
            last_reg  <= pend_last_reg;
        end
    end

    assign m_valid      = valid_reg;
    assign m_conv_value = value_reg;
    assign m_out_last   = last_reg;

endmodule

/* rtl/truncated_causal_convolution_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truncated_causal_convolution_unit
// First N terms of the linear convolution of two q0.16 sequences.
//
// The input channel takes one pair (first_elem, second_elem) per transfer;
// in_last on a pair ends the run and sets N (at most 64, pairs past 64 are
// dropped but their last mark still ends the run). The result channel then
// gives N terms c[i] = sum a[j]*b[i-j], rounded half up and saturated, with
// out_last on the final term.
// The input stays ready throughout loading. The terms come from a chain of 64
// cells that each hold a[k] and b[k]; every step shifts b one cell toward the
// head and passes the partial sums down, so the head sum is one new term.
// After the last transfer the chain steps and the new head sum is rounded into
// the output register, at one term per cycle while the receiver is ready.
// The input stays closed from the last transfer until the final term has
// entered the output register. A stalled receiver holds the output register
// and the chain stops stepping until it is taken.
// Reset clears the sequencer and the output valid; stored data is kept.
// ----------------------------------------------------------------------------
module truncated_causal_convolution_unit
    import tcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_first_elem,
    input  logic [DATA_W-1:0] s_second_elem,
    input  logic              s_in_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_conv_value,
    output logic              m_out_last
);

    tcc_ctrl_t         ctrl;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] b_chain [0:MAX_LEN];
    logic [ACC_W-1:0]  s_chain [0:MAX_LEN];

    assign b_chain[MAX_LEN] = '0;
    assign s_chain[MAX_LEN] = '0;

    tcc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_last    (s_in_last),
        .head_sum     (s_chain[0]),
        .ctrl         (ctrl),
        .wr_idx       (wr_idx),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_conv_value (m_conv_value),
        .m_out_last   (m_out_last)
    );

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        tcc_ctrl_t cell_ctrl;

        assign cell_ctrl.wr  = ctrl.wr && (wr_idx == IDX_W'(k));
        assign cell_ctrl.adv = ctrl.adv;
        assign cell_ctrl.clr = ctrl.clr;

        tcc_cell u_cell (
            .aclk  (aclk),
            .ctrl  (cell_ctrl),
            .a_in  (s_first_elem),
            .b_in  (s_second_elem),
            .x_in  (b_chain[0]),
            .b_nbr (b_chain[k+1]),
            .s_nbr (s_chain[k+1]),
            .b_out (b_chain[k]),
            .s_out (s_chain[k])
        );
    end

endmodule

/* rtl/tcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for the truncated causal convolution unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module tcc_checker
    import tcc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [DATA_W-1:0] s_first_elem,
    input logic [DATA_W-1:0] s_second_elem,
    input logic              s_in_last,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_conv_value,
    input logic              m_out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_conv_value) && $stable(m_out_last))
        else $error("result changed while stalled");

    // last pair closes the input
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_in_last |=> !s_ready)
        else $error("input open after last transfer");

    // other pairs keep the input open
    a_load_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_in_last |=> s_ready)
        else $error("input closed during load");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind truncated_causal_convolution_unit tcc_checker u_tcc_checker (.*);
